// File: rtl/disparity_median_consistency_check_assert.svh
// assertion macros shared by the disparity median consistency check
`ifndef DISPARITY_MEDIAN_CONSISTENCY_CHECK_ASSERT_SVH
`define DISPARITY_MEDIAN_CONSISTENCY_CHECK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DMCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmcc same-cycle check failed");

// next-cycle implication, checked out of reset
`define DMCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmcc next-cycle check failed");

`endif

// File: rtl/dmcc_pkg.sv
// shared types and constants of the disparity median consistency check
package dmcc_pkg;

  localparam int WIN_TAPS   = 9;
  localparam int CENTER_TAP = 4;
  localparam int VAL_W      = 16;
  localparam int DISP_W     = 15;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 4;
  localparam int REASON_W   = 3;
  localparam int IDX_W      = 3;

  localparam logic [CNT_W-1:0] MIN_IN_RANGE = CNT_W'(5);

  // reject reasons
  localparam logic [REASON_W-1:0] REASON_OK       = 3'd0;
  localparam logic [REASON_W-1:0] REASON_BORDER   = 3'd1;
  localparam logic [REASON_W-1:0] REASON_CENTER   = 3'd2;
  localparam logic [REASON_W-1:0] REASON_TOO_FEW  = 3'd3;
  localparam logic [REASON_W-1:0] REASON_FAR      = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_DISP   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_DISP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MED_TOL    = 3'd4;

  localparam logic [DIM_W-1:0]  RST_MAP_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT = 13'd480;
  localparam logic [DISP_W-1:0] RST_MIN_DISP   = 15'd16;
  localparam logic [DISP_W-1:0] RST_MAX_DISP   = 15'd4096;
  localparam logic [DISP_W-1:0] RST_MED_TOL    = 15'd24;

  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [DISP_W-1:0]  disp_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef val_t [WIN_TAPS-1:0] win_t;

  typedef struct packed {
    dim_t  map_width;
    dim_t  map_height;
    disp_t min_disp;
    disp_t max_disp;
    disp_t med_tol;
  } cfg_t;

  typedef struct packed {
    logic  center_ok;
    cnt_t  count;
    disp_t median;
  } med_t;

  typedef struct packed {
    logic                consistent;
    disp_t               disparity;
    logic [REASON_W-1:0] reason;
  } res_t;

endpackage

// File: rtl/dmcc_median.sv
// in-range filter and rank-based median select over the 3x3 window
module dmcc_median (
  input  dmcc_pkg::win_t  win,
  input  dmcc_pkg::disp_t min_disp,
  input  dmcc_pkg::disp_t max_disp,
  output dmcc_pkg::med_t  med
);
  import dmcc_pkg::*;

  logic [WIN_TAPS-1:0] keep;
  cnt_t                rank [WIN_TAPS];
  cnt_t                count;
  cnt_t                mid;
  disp_t               median;

  always_comb begin
    for (int i = 0; i < WIN_TAPS; i++) begin
      // negative values never pass since the sign bit is tested
      keep[i] = !win[i][VAL_W-1] && (win[i][DISP_W-1:0] >= min_disp) &&
                (win[i][DISP_W-1:0] <= max_disp);
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      count = count + CNT_W'(keep[i]);
    end
  end

  // stable rank: equal values ordered by tap position
  always_comb begin
    for (int i = 0; i < WIN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_TAPS; j++) begin
        if (keep[j] && j != i &&
            ((win[j][DISP_W-1:0] < win[i][DISP_W-1:0]) ||
             ((win[j][DISP_W-1:0] == win[i][DISP_W-1:0]) && j < i))) begin
          rank[i] = rank[i] + CNT_W'(1);
        end
      end
    end
  end

  assign mid = count >> 1;

  // at most one kept tap holds the middle rank (exactly one when any tap is kept)
  always_comb begin
    median = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      if (keep[i] && rank[i] == mid) begin
        median = median | win[i][DISP_W-1:0];
      end
    end
  end

  assign med.center_ok = keep[CENTER_TAP];
  assign med.count     = count;
  assign med.median    = median;

endmodule

// File: rtl/dmcc_check.sv
// border, range, count and median distance decision
module dmcc_check (
  input  dmcc_pkg::coord_t pixel_x,
  input  dmcc_pkg::coord_t pixel_y,
  input  dmcc_pkg::val_t   center,
  input  dmcc_pkg::cfg_t   cfg,
  input  dmcc_pkg::med_t   med,
  output dmcc_pkg::res_t   res
);
  import dmcc_pkg::*;

  logic  border;
  disp_t gap;
  logic  far;

  assign border = (pixel_x == '0) || (pixel_y == '0) ||
                  ((DIM_W'(pixel_x) + DIM_W'(1)) >= cfg.map_width) ||
                  ((DIM_W'(pixel_y) + DIM_W'(1)) >= cfg.map_height);

  // center is known non-negative once it passed the range test
  assign gap = (center[DISP_W-1:0] >= med.median) ? center[DISP_W-1:0] - med.median
                                                  : med.median - center[DISP_W-1:0];
  assign far = gap > cfg.med_tol;

  always_comb begin
    res.consistent = 1'b0;
    res.disparity  = '0;
    if (border) begin
      res.reason = REASON_BORDER;
    end else if (!med.center_ok) begin
      res.reason = REASON_CENTER;
    end else if (med.count < MIN_IN_RANGE) begin
      res.reason = REASON_TOO_FEW;
    end else if (far) begin
      res.reason = REASON_FAR;
    end else begin
      res.reason     = REASON_OK;
      res.consistent = 1'b1;
      res.disparity  = med.median;
    end
  end

endmodule

// File: rtl/disparity_median_consistency_check.sv
// top level of the disparity median consistency check
//
// Usage: one query word enters on the in_ channel (pixel coordinate plus the
// nine window disparities, Q12.4) when in_valid is high and in_stall is low.
// One result word leaves on the out_ channel when out_valid is high and
// out_stall is low: consistent flag, median disparity (0 on rejection) and
// the reject reason.
// The path runs through an input register, then the range filter, rank
// based median select and decision logic, then the result register.
// Throughput is one word per cycle while out_stall is low; the single
// combinational pass between the two registers sets that figure.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; in_stall rises only when both are full.
// Registers are written over the cfg_ channel (cfg_ready is always high) and
// should only change while no query is in flight; unknown indexes are ignored.
// Synchronous reset empties both stages and loads the register defaults:
// width 640, height 480, disparity range 16..4096, tolerance 24.
`include "disparity_median_consistency_check_assert.svh"

module disparity_median_consistency_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dmcc_pkg::coord_t          in_pixel_x,
  input  dmcc_pkg::coord_t          in_pixel_y,
  input  dmcc_pkg::val_t            in_win_up_left,
  input  dmcc_pkg::val_t            in_win_up,
  input  dmcc_pkg::val_t            in_win_up_right,
  input  dmcc_pkg::val_t            in_win_left,
  input  dmcc_pkg::val_t            in_win_center,
  input  dmcc_pkg::val_t            in_win_right,
  input  dmcc_pkg::val_t            in_win_down_left,
  input  dmcc_pkg::val_t            in_win_down,
  input  dmcc_pkg::val_t            in_win_down_right,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_consistent,
  output dmcc_pkg::disp_t           out_disparity_out,
  output logic [dmcc_pkg::REASON_W-1:0] out_reject_reason,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dmcc_pkg::IDX_W-1:0] cfg_index,
  input  dmcc_pkg::disp_t           cfg_data
);
  import dmcc_pkg::*;

  cfg_t   cfg_r;
  logic   s1_valid_r;
  coord_t s1_x_r;
  coord_t s1_y_r;
  win_t   s1_win_r;
  logic   out_valid_r;
  res_t   out_res_r;

  logic   s1_load;
  logic   out_load;
  med_t   med;
  res_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_width  <= RST_MAP_WIDTH;
      cfg_r.map_height <= RST_MAP_HEIGHT;
      cfg_r.min_disp   <= RST_MIN_DISP;
      cfg_r.max_disp   <= RST_MAX_DISP;
      cfg_r.med_tol    <= RST_MED_TOL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH:  cfg_r.map_width  <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT: cfg_r.map_height <= cfg_data[DIM_W-1:0];
        REG_MIN_DISP:   cfg_r.min_disp   <= cfg_data;
        REG_MAX_DISP:   cfg_r.max_disp   <= cfg_data;
        REG_MED_TOL:    cfg_r.med_tol    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register frees up when empty or when its word is taken
  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_x_r                  <= in_pixel_x;
      s1_y_r                  <= in_pixel_y;
      s1_win_r[0]             <= in_win_up_left;
      s1_win_r[1]             <= in_win_up;
      s1_win_r[2]             <= in_win_up_right;
      s1_win_r[3]             <= in_win_left;
      s1_win_r[CENTER_TAP]    <= in_win_center;
      s1_win_r[5]             <= in_win_right;
      s1_win_r[6]             <= in_win_down_left;
      s1_win_r[7]             <= in_win_down;
      s1_win_r[8]             <= in_win_down_right;
    end
  end

  dmcc_median u_median (
    .win      (s1_win_r),
    .min_disp (cfg_r.min_disp),
    .max_disp (cfg_r.max_disp),
    .med      (med)
  );

  dmcc_check u_check (
    .pixel_x (s1_x_r),
    .pixel_y (s1_y_r),
    .center  (s1_win_r[CENTER_TAP]),
    .cfg     (cfg_r),
    .med     (med),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_consistent    = out_res_r.consistent;
  assign out_disparity_out = out_res_r.disparity;
  assign out_reject_reason = out_res_r.reason;

  `DMCC_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid_r && (out_res_r.reason != REASON_OK), (out_res_r.disparity == '0) && !out_res_r.consistent)
  `DMCC_ASSERT_NOW(a_ok_flag, clk, rst_n, out_valid_r && (out_res_r.reason == REASON_OK), out_res_r.consistent)
  `DMCC_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r && out_stall)
  `DMCC_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, s1_valid_r)

endmodule
